### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define AST_SAME(lbl, clk, rst_n, ante, cons, msg)
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Types, codes and helpers shared by the device scan sequencer
// ----------------------------------------------------------------------------
package pcs_pkg;

	// last bus visited is BUS_LIMIT-1
	localparam int BUS_LIMIT = 256;
	localparam logic [8:0] BUS_LAST = 9'(BUS_LIMIT - 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WANT_VENDOR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WANT_DEVICE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WANT_CLASS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WANT_SUBCLS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WANT_PROG_IF = 3'd5;

	// configuration space offsets and fields
	localparam logic [31:0] ADDR_ENABLE = 32'h8000_0000;
	localparam logic [7:0]  OFF_MASK    = 8'hFC;
	localparam logic [7:0]  OFF_ID      = 8'h00;
	localparam logic [7:0]  OFF_CLASS   = 8'h08;
	localparam logic [7:0]  OFF_HDR     = 8'h0C;
	localparam logic [7:0]  OFF_BAR     = 8'h10;
	localparam logic [7:0]  OFF_IRQ     = 8'h3C;
	localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
	localparam logic [2:0]  FUNC_LAST   = 3'd7;
	localparam logic [4:0]  SLOT_LAST   = 5'd31;
	localparam int          HDR_MF_BIT  = 23;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_ID    = 3'd1,
		PH_HDR   = 3'd2,
		PH_CLASS = 3'd3,
		PH_BAR   = 3'd4,
		PH_IRQ   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		RK_READ  = 2'd0,
		RK_FOUND = 2'd1,
		RK_NONE  = 2'd2
	} result_kind_t;

	typedef struct packed {
		logic        search_mode;
		logic [15:0] want_vendor;
		logic [15:0] want_device;
		logic [7:0]  want_class;
		logic [7:0]  want_subclass;
		logic [7:0]  want_prog_if;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  cur_bus;
		logic [4:0]  cur_slot;
		logic [2:0]  cur_func;
		logic [31:0] held_id;
		logic [31:0] held_bar;
	} scan_state_t;

	typedef struct packed {
		result_kind_t kind;
		logic [31:0]  config_address;
		logic [7:0]   dev_bus;
		logic [4:0]   dev_slot;
		logic [2:0]   dev_func;
		logic [15:0]  dev_vendor;
		logic [15:0]  dev_device;
		logic [31:0]  dev_bar0;
		logic [7:0]   dev_irq;
	} result_t;

	// packed config-address read request
	function automatic logic [31:0] pack_addr(
		input logic [7:0] bus,
		input logic [4:0] slot,
		input logic [2:0] func,
		input logic [7:0] off
	);
		return ADDR_ENABLE | {8'h00, bus, slot, func, off & OFF_MASK};
	endfunction

	function automatic result_t read_req(
		input logic [7:0] bus,
		input logic [4:0] slot,
		input logic [2:0] func,
		input logic [7:0] off
	);
		result_t r;
		r = '0;
		r.kind = RK_READ;
		r.config_address = pack_addr(bus, slot, func, off);
		return r;
	endfunction

endpackage

### rtl/pci_config_device_scan.sv
// ----------------------------------------------------------------------------
// pci_config_device_scan
// Bus scan sequencer: walks bus, slot and function and finds a device
// ----------------------------------------------------------------------------
// Usage:
//   Input words (kind, read_data) arrive on in_valid / in_stall. kind 0 starts
//   a scan from bus 0 slot 0 function 0; kind 1 hands over the dword returned
//   for the last read request. Each input word gives at most one result word
//   on out_valid / out_stall: a read request (config_address), a found device
//   or a not-found report at the end of the scan.
//   Search settings are written on cfg_valid / cfg_ready (always ready) by
//   register index while no scan word is in flight.
//   Path: an accepted word goes through the input register, then the result
//   register. Throughput: one word per cycle unless out_stall holds a result,
//   set by the combinational step logic between the two registers.
//   A stalled result holds; the input register keeps taking a word while the
//   result register is empty or draining, and in_stall rises only when both
//   are full. Reset clears the scan position, phase and search registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pci_config_device_scan
	import pcs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  logic [31:0]           read_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            result_kind,
	output logic [31:0]           config_address,
	output logic [7:0]            dev_bus,
	output logic [4:0]            dev_slot,
	output logic [2:0]            dev_func,
	output logic [15:0]           dev_vendor,
	output logic [15:0]           dev_device,
	output logic [31:0]           dev_bar0,
	output logic [7:0]            dev_irq
);

	cfg_t        cfg;
	scan_state_t state_q;
	scan_state_t state_nxt;
	result_t     step_res;
	result_t     res_q;
	logic        step_emit;
	logic        valid_s1;
	logic        kind_s1;
	logic [31:0] data_s1;
	logic        out_valid_q;
	logic        take;
	logic        in_acc;

	assign cfg_ready = 1'b1;

	pcs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pcs_step u_step (
		.st   (state_q),
		.cfg  (cfg),
		.kind (kind_s1),
		.data (data_s1),
		.nxt  (state_nxt),
		.emit (step_emit),
		.res  (step_res)
	);

	// stage 1 word is processed when its result has a place to go
	assign take = valid_s1 && (!step_emit || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !take;
	assign in_acc = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1 <= kind;
			data_s1 <= read_data;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
		end else if (take) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && step_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && step_emit) begin
			res_q <= step_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = res_q.kind;
	assign config_address = res_q.config_address;
	assign dev_bus        = res_q.dev_bus;
	assign dev_slot       = res_q.dev_slot;
	assign dev_func       = res_q.dev_func;
	assign dev_vendor     = res_q.dev_vendor;
	assign dev_device     = res_q.dev_device;
	assign dev_bar0       = res_q.dev_bar0;
	assign dev_irq        = res_q.dev_irq;

	// checks
	`AST_SAME(a_stall_full, clk, arst_n, in_stall, valid_s1 && out_valid_q, "stall without full stages")
	`AST_NEXT(a_emit_shown, clk, arst_n, take && step_emit, out_valid_q, "produced word not shown")
	`AST_SAME(a_read_enable, clk, arst_n, out_valid_q && res_q.kind == RK_READ, res_q.config_address[31] && res_q.dev_bar0 == 32'h0, "bad read request word")
	`AST_SAME(a_found_noaddr, clk, arst_n, out_valid_q && res_q.kind == RK_FOUND, res_q.config_address == 32'h0, "found word carries an address")

endmodule

### rtl/pcs_cfg.sv
// ----------------------------------------------------------------------------
// pcs_cfg
// Search configuration registers written through the config port
// ----------------------------------------------------------------------------
module pcs_cfg
	import pcs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register write, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SEARCH_MODE:  cfg_q.search_mode   <= wr_data[0];
				CFG_WANT_VENDOR:  cfg_q.want_vendor   <= wr_data[15:0];
				CFG_WANT_DEVICE:  cfg_q.want_device   <= wr_data[15:0];
				CFG_WANT_CLASS:   cfg_q.want_class    <= wr_data[7:0];
				CFG_WANT_SUBCLS:  cfg_q.want_subclass <= wr_data[7:0];
				CFG_WANT_PROG_IF: cfg_q.want_prog_if  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/pcs_step.sv
// ----------------------------------------------------------------------------
// pcs_step
// Next-state and result logic of the scan for one input word
// ----------------------------------------------------------------------------
module pcs_step
	import pcs_pkg::*;
(
	input  scan_state_t st,
	input  cfg_t        cfg,
	input  logic        kind,
	input  logic [31:0] data,
	output scan_state_t nxt,
	output logic        emit,
	output result_t     res
);

	scan_state_t adv_st;
	result_t     adv_res;
	logic        whole_slot;
	logic        id_match;
	logic        class_match;

	// header without multifunction bit skips the rest of the slot
	assign whole_slot = (st.phase == PH_HDR) && !data[HDR_MF_BIT];

	assign id_match = (data[15:0] == cfg.want_vendor) && (data[31:16] == cfg.want_device);
	assign class_match = (data[31:24] == cfg.want_class) &&
		(data[23:16] == cfg.want_subclass) && (data[15:8] == cfg.want_prog_if);

	// move to next function, slot or bus, or end the scan after the last bus
	always_comb begin
		adv_st = st;
		adv_res = '0;
		if (!whole_slot && st.cur_func < FUNC_LAST) begin
			adv_st.cur_func = st.cur_func + 3'd1;
			adv_st.phase = PH_ID;
		end else if (st.cur_slot < SLOT_LAST) begin
			adv_st.cur_func = '0;
			adv_st.cur_slot = st.cur_slot + 5'd1;
			adv_st.phase = PH_ID;
		end else if ({1'b0, st.cur_bus} >= BUS_LAST) begin
			adv_st.cur_func = '0;
			adv_st.cur_slot = '0;
			adv_st.cur_bus = '0;
			adv_st.phase = PH_IDLE;
		end else begin
			adv_st.cur_func = '0;
			adv_st.cur_slot = '0;
			adv_st.cur_bus = st.cur_bus + 8'd1;
			adv_st.phase = PH_ID;
		end
		if (adv_st.phase == PH_IDLE) begin
			adv_res.kind = RK_NONE;
		end else begin
			adv_res = read_req(adv_st.cur_bus, adv_st.cur_slot, adv_st.cur_func, OFF_ID);
		end
	end

	// phase decode
	always_comb begin
		nxt = st;
		emit = 1'b0;
		res = '0;
		if (!kind) begin
			nxt.cur_bus = '0;
			nxt.cur_slot = '0;
			nxt.cur_func = '0;
			nxt.held_id = '0;
			nxt.held_bar = '0;
			nxt.phase = PH_ID;
			emit = 1'b1;
			res = read_req(8'h00, 5'h00, 3'h0, OFF_ID);
		end else begin
			case (st.phase)
				PH_ID: begin
					emit = 1'b1;
					if (data[15:0] == VENDOR_NONE) begin
						nxt = adv_st;
						res = adv_res;
					end else if (cfg.search_mode) begin
						nxt.held_id = data;
						nxt.phase = PH_CLASS;
						res = read_req(st.cur_bus, st.cur_slot, st.cur_func, OFF_CLASS);
					end else if (id_match) begin
						nxt.held_id = data;
						nxt.phase = PH_BAR;
						res = read_req(st.cur_bus, st.cur_slot, st.cur_func, OFF_BAR);
					end else if (st.cur_func == 3'd0) begin
						nxt.held_id = data;
						nxt.phase = PH_HDR;
						res = read_req(st.cur_bus, st.cur_slot, st.cur_func, OFF_HDR);
					end else begin
						nxt = adv_st;
						nxt.held_id = data;
						res = adv_res;
					end
				end
				PH_HDR: begin
					emit = 1'b1;
					nxt = adv_st;
					res = adv_res;
				end
				PH_CLASS: begin
					emit = 1'b1;
					if (class_match) begin
						nxt.phase = PH_BAR;
						res = read_req(st.cur_bus, st.cur_slot, st.cur_func, OFF_BAR);
					end else begin
						nxt = adv_st;
						res = adv_res;
					end
				end
				PH_BAR: begin
					emit = 1'b1;
					nxt.held_bar = data;
					nxt.phase = PH_IRQ;
					res = read_req(st.cur_bus, st.cur_slot, st.cur_func, OFF_IRQ);
				end
				PH_IRQ: begin
					emit = 1'b1;
					nxt.phase = PH_IDLE;
					res.kind = RK_FOUND;
					res.dev_bus = st.cur_bus;
					res.dev_slot = st.cur_slot;
					res.dev_func = st.cur_func;
					res.dev_vendor = st.held_id[15:0];
					res.dev_device = st.held_id[31:16];
					res.dev_bar0 = st.held_bar;
					res.dev_irq = data[7:0];
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
		end
	end

endmodule
